/* rtl/sirs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sirs_pkg: shared types and constants of the radix symbol converter
// Configuration record, register indexes, character codes, reciprocal table
// for the digit extraction loop and the back-end state encoding.
// ----------------------------------------------------------------------------
package sirs_pkg;

  // Configuration registers as one record
  typedef struct packed {
    logic [4:0]  radix;
    logic [63:0] sym_lo;
    logic [63:0] sym_hi;
  } cfg_t;

  // Register indexes on the configuration channel
  typedef enum logic [1:0] {
    CFG_RADIX  = 2'd0,
    CFG_SYM_LO = 2'd1,
    CFG_SYM_HI = 2'd2
  } cfg_idx_e;

  localparam cfg_t CFG_RESET = '{
    radix:  5'd10,
    sym_lo: 64'd3978425819141910832,
    sym_hi: 64'd14648
  };

  // Character codes
  localparam logic [7:0] CODE_PLUS  = 8'd43;
  localparam logic [7:0] CODE_MINUS = 8'd45;
  localparam logic [7:0] CODE_SPACE = 8'd32;
  localparam logic [4:0] MIN_RADIX  = 5'd2;

  // Reciprocal floor(2^32 / b), indexed by b - 1 (entry for b = 1 unused)
  localparam int unsigned RecipBits = 32;
  localparam logic [63:0] RecipOne = 64'h1_0000_0000;
  localparam logic [31:0] RECIP [16] = '{
    32'hFFFF_FFFF,
    32'(RecipOne / 64'd2),
    32'(RecipOne / 64'd3),
    32'(RecipOne / 64'd4),
    32'(RecipOne / 64'd5),
    32'(RecipOne / 64'd6),
    32'(RecipOne / 64'd7),
    32'(RecipOne / 64'd8),
    32'(RecipOne / 64'd9),
    32'(RecipOne / 64'd10),
    32'(RecipOne / 64'd11),
    32'(RecipOne / 64'd12),
    32'(RecipOne / 64'd13),
    32'(RecipOne / 64'd14),
    32'(RecipOne / 64'd15),
    32'(RecipOne / 64'd16)
  };

  // Back-end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_FIX,
    BK_SIGN,
    BK_READ,
    BK_EMIT
  } back_state_e;

  // Symbol code of a digit from the alphabet registers
  function automatic logic [7:0] symbol_of(input cfg_t c, input logic [3:0] d);
    logic [127:0] all;
    all = {c.sym_hi, c.sym_lo};
    return all[{d, 3'b000} +: 8];
  endfunction

endpackage
`default_nettype wire

/* rtl/sirs_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sirs_if: channel interfaces of the radix symbol converter
// Input value channel, output symbol channel and configuration write channel.
// ----------------------------------------------------------------------------
interface sirs_value_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sirs_symbol_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last;
  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

interface sirs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* rtl/sirs_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sirs_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sirs_ram #(
  parameter int unsigned Width = 4,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

/* rtl/sirs_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sirs_front: configuration registers and input classification
// Holds the alphabet registers, checks the alphabet, takes input values and
// queues sign and magnitude of those that produce symbols.
// ----------------------------------------------------------------------------
module sirs_front #(
  parameter int unsigned MAX_SYMBOLS = 16,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  sirs_value_if.sink                 in_i,
  sirs_cfg_if.sink                   cfg_i,
  output sirs_pkg::cfg_t             cfg_o,
  output logic                       push_valid_o,
  output logic [VALUE_BITS:0]        push_data_o,
  input  wire logic                  push_ready_i
);
  import sirs_pkg::*;

  localparam logic [4:0] RadixMax = 5'(MAX_SYMBOLS);

  cfg_t                  cfg_q;
  logic                  alpha_ok;
  logic [VALUE_BITS-1:0] val;
  logic                  neg;
  logic [VALUE_BITS-1:0] mag;

  // Configuration registers, always writable
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_RADIX:  cfg_q.radix  <= cfg_i.data[4:0];
        CFG_SYM_LO: cfg_q.sym_lo <= cfg_i.data;
        CFG_SYM_HI: cfg_q.sym_hi <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

  // Alphabet check: size, forbidden codes, duplicates among active symbols
  always_comb begin
    alpha_ok = (cfg_q.radix >= MIN_RADIX) && (cfg_q.radix <= RadixMax);
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      if (5'(i) < cfg_q.radix) begin
        if ((symbol_of(cfg_q, 4'(i)) <= CODE_SPACE) ||
            (symbol_of(cfg_q, 4'(i)) == CODE_PLUS) ||
            (symbol_of(cfg_q, 4'(i)) == CODE_MINUS)) begin
          alpha_ok = 1'b0;
        end
        for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
          if ((5'(j) < cfg_q.radix) &&
              (symbol_of(cfg_q, 4'(j)) == symbol_of(cfg_q, 4'(i)))) begin
            alpha_ok = 1'b0;
          end
        end
      end
    end
  end

  // Sign and magnitude; the magnitude of the most negative value still fits
  assign val = in_i.value[VALUE_BITS-1:0];
  assign neg = val[VALUE_BITS-1];
  assign mag = neg ? (~val + 1'b1) : val;

  // Values under an invalid alphabet are taken and dropped
  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid && alpha_ok;
  assign push_data_o  = {neg, mag};

endmodule
`default_nettype wire

/* rtl/sirs_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sirs_queue: small FIFO between front and back
// Register-based FIFO, depth a power of two, valid/ready on both sides.
// ----------------------------------------------------------------------------
module sirs_queue #(
  parameter int unsigned Width = 33,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [Width-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic      [Width-1:0] pop_data_o
);

  localparam int unsigned PtrW   = $clog2(Depth);
  localparam int unsigned CountW = $clog2(Depth + 1);

  logic [Width-1:0]  entry_q [Depth];
  logic [PtrW-1:0]   wptr_q, wptr_d;
  logic [PtrW-1:0]   rptr_q, rptr_d;
  logic [CountW-1:0] count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != CountW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  // Pointer and fill bookkeeping
  always_comb begin
    wptr_d  = push ? wptr_q + 1'b1 : wptr_q;
    rptr_d  = pop ? rptr_q + 1'b1 : rptr_q;
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

/* rtl/sirs_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sirs_back: digit extraction and symbol emission
// Splits the magnitude into digits with a reciprocal multiply and one
// correction step, stacks them in a RAM, then emits sign and symbols
// most significant first through an output register.
// ----------------------------------------------------------------------------
module sirs_back #(
  parameter int unsigned MAX_SYMBOLS = 16,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire sirs_pkg::cfg_t        cfg_i,
  input  wire logic                  pop_valid_i,
  output logic                       pop_ready_o,
  input  wire logic [VALUE_BITS:0]   pop_data_i,
  sirs_symbol_if.source              out_o
);
  import sirs_pkg::*;

  localparam int unsigned DigitW = $clog2(MAX_SYMBOLS);
  localparam int unsigned AddrW  = $clog2(VALUE_BITS);
  localparam int unsigned CntW   = $clog2(VALUE_BITS + 1);
  localparam int unsigned WideW  = VALUE_BITS + 5;

  back_state_e           state_q, state_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  neg_q, neg_d;
  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic [63:0]           prod_q;
  logic                  out_valid_q;
  logic [7:0]            out_sym_q, out_sym_d;
  logic                  out_last_q, out_last_d;
  logic                  out_load;
  logic                  slot_free;
  logic                  prod_load;

  logic [31:0]           recip;
  logic [VALUE_BITS-1:0] q_est;
  logic [WideW-1:0]      q_base;
  logic [WideW-1:0]      rem_wide;
  logic [4:0]            rem_raw;
  logic                  rem_fix;
  logic [4:0]            rem;
  logic [VALUE_BITS-1:0] quot;

  logic                  ram_we;
  logic [AddrW-1:0]      ram_raddr;
  logic [DigitW-1:0]     ram_rdata;

  // Quotient estimate from the reciprocal, then one correction step
  assign recip    = RECIP[4'(cfg_i.radix - 5'd1)];
  assign q_est    = prod_q[RecipBits +: VALUE_BITS];
  assign q_base   = WideW'(q_est) * WideW'(cfg_i.radix);
  assign rem_wide = WideW'(mag_q) - q_base;
  assign rem_raw  = rem_wide[4:0];
  assign rem_fix  = (rem_raw >= cfg_i.radix);
  assign rem      = rem_fix ? (rem_raw - cfg_i.radix) : rem_raw;
  assign quot     = rem_fix ? (q_est + 1'b1) : q_est;

  // Digit stack
  assign ram_raddr = AddrW'(cnt_q - 1'b1);

  sirs_ram #(
    .Width (DigitW),
    .Depth (VALUE_BITS)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[AddrW-1:0]),
    .wdata_i (rem[DigitW-1:0]),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign slot_free = !out_valid_q || out_o.ready;

  // Sequencer: next state and controls
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    pop_ready_o = 1'b0;
    prod_load   = 1'b0;
    ram_we      = 1'b0;
    out_load    = 1'b0;
    out_sym_d   = out_sym_q;
    out_last_d  = out_last_q;
    unique case (state_q)
      BK_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          neg_d   = pop_data_i[VALUE_BITS];
          mag_d   = pop_data_i[VALUE_BITS-1:0];
          cnt_d   = '0;
          state_d = BK_MUL;
        end
      end
      BK_MUL: begin
        prod_load = 1'b1;
        state_d   = BK_FIX;
      end
      BK_FIX: begin
        ram_we = 1'b1;
        cnt_d  = cnt_q + 1'b1;
        if (quot == '0) begin
          state_d = BK_SIGN;
        end else begin
          mag_d   = quot;
          state_d = BK_MUL;
        end
      end
      BK_SIGN: begin
        if (!neg_q) begin
          state_d = BK_READ;
        end else if (slot_free) begin
          out_load   = 1'b1;
          out_sym_d  = CODE_MINUS;
          out_last_d = 1'b0;
          state_d    = BK_READ;
        end
      end
      BK_READ: begin
        state_d = BK_EMIT;
      end
      BK_EMIT: begin
        if (slot_free) begin
          out_load   = 1'b1;
          out_sym_d  = symbol_of(cfg_i, 4'(ram_rdata));
          out_last_d = (cnt_q == CntW'(1));
          cnt_d      = cnt_q - 1'b1;
          state_d    = (cnt_q == CntW'(1)) ? BK_IDLE : BK_READ;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    neg_q      <= neg_d;
    mag_q      <= mag_d;
    out_sym_q  <= out_sym_d;
    out_last_q <= out_last_d;
    if (prod_load) begin
      prod_q <= 64'(32'(mag_q)) * 64'(recip);
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.symbol = out_sym_q;
  assign out_o.last   = out_last_q;

  // Emission never starts on an empty stack
  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_EMIT) |-> (cnt_q != '0))
    else $error("emit with empty digit stack");

  // Corrected remainder is a proper digit
  a_rem_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_FIX) |-> (rem < cfg_i.radix))
    else $error("remainder not below radix");

  // The minus sign is never the closing symbol
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_sym_q == CODE_MINUS)) |-> !out_last_q)
    else $error("minus sign marked last");

  // Digit count stays within the stack
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(VALUE_BITS))
    else $error("digit count beyond stack depth");

endmodule
`default_nettype wire

/* rtl/signed_integer_to_radix_symbols.sv */
`default_nettype none
// A value is split into digits with one reciprocal multiply (BK_MUL) and one
// correction (BK_FIX) per digit, then each symbol is emitted with a stack RAM
// read (BK_READ) and an output register load (BK_EMIT), after a sign step
// (BK_SIGN) and the hand-off from the queue (BK_IDLE). The front takes new
// values into a two-entry queue while the back works, so input and output
// stall independently. Values arriving while the alphabet is invalid are
// taken and produce no symbols.
// ----------------------------------------------------------------------------
// signed_integer_to_radix_symbols: signed integer to text in a set radix
// Top level: front (config, classification), queue, back (digits, symbols).
// ----------------------------------------------------------------------------
module signed_integer_to_radix_symbols #(
  parameter int unsigned MAX_SYMBOLS = 16,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  sirs_value_if.sink    in_i,
  sirs_symbol_if.source out_o,
  sirs_cfg_if.sink      cfg_i
);
  import sirs_pkg::*;

  localparam int unsigned QueueDepth = 2;

  cfg_t                cfg;
  logic                push_valid, push_ready;
  logic [VALUE_BITS:0] push_data;
  logic                pop_valid, pop_ready;
  logic [VALUE_BITS:0] pop_data;

  sirs_front #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_i),
    .cfg_o        (cfg),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  sirs_queue #(
    .Width (VALUE_BITS + 1),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  sirs_back #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_o       (out_o)
  );

endmodule
`default_nettype wire
